@@ rtl/fifo_priority_ready_queue_macros.svh @@
// Assertion macros shared by the ready queue RTL.
// Used by modules that have clk and rst_n in scope.
`ifndef FIFO_PRIORITY_READY_QUEUE_MACROS_SVH
`define FIFO_PRIORITY_READY_QUEUE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FPRQ_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ready queue check failed");
`define FPRQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ready queue check failed");
`else
`define FPRQ_ASSERT_SAME(label, ante, cons)
`define FPRQ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/fprq_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the priority ready queue.
// No dependencies.
package fprq_pkg;
  localparam int DEF_CAPACITY = 16;
  localparam int HANDLE_W     = 16;
  localparam int PRIO_W       = 8;

  typedef enum logic [1:0] {
    ACT_ENQUEUE = 2'd0,
    ACT_DEQUEUE = 2'd1,
    ACT_PICK    = 2'd2,
    ACT_NOP     = 2'd3
  } action_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [PRIO_W-1:0]   prio;
  } entry_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;
endpackage

@@ rtl/fprq_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and result transactions.
// Depends on fprq_pkg.
interface fprq_in_if;
  logic                        valid;
  logic                        ready;
  fprq_pkg::action_t           action;
  logic [fprq_pkg::HANDLE_W-1:0] proc_handle;
  logic [fprq_pkg::PRIO_W-1:0]   proc_priority;

  modport source (output valid, action, proc_handle, proc_priority, input ready);
  modport sink (input valid, action, proc_handle, proc_priority, output ready);
endinterface

interface fprq_out_if;
  logic                        valid;
  logic                        ready;
  logic [fprq_pkg::HANDLE_W-1:0] out_handle;
  logic [fprq_pkg::PRIO_W-1:0]   out_priority;
  logic                        found;
  logic                        queue_empty;
  logic                        overflow;

  modport source (output valid, out_handle, out_priority, found, queue_empty, overflow,
                  input ready);
  modport sink (input valid, out_handle, out_priority, found, queue_empty, overflow,
                output ready);
endinterface

@@ rtl/fprq_cell.sv @@
`timescale 1ns / 1ps
// One storage cell of the queue chain: loads a new entry or takes its neighbour's.
// Depends on fprq_pkg.
module fprq_cell (
  input  logic                clk,
  input  fprq_pkg::cell_ctl_t ctl,
  input  fprq_pkg::entry_t    enq_data,
  input  fprq_pkg::entry_t    shift_in,
  output fprq_pkg::entry_t    q
);
  import fprq_pkg::*;

  entry_t data_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data_r <= enq_data;
    end else if (ctl.shift) begin
      data_r <= shift_in;
    end
  end

  assign q = data_r;
endmodule

@@ rtl/fprq_tree.sv @@
`timescale 1ns / 1ps
// Registered max tree over the cells; ties go to the lower (older) position.
// Depends on fprq_pkg.
module fprq_tree #(
  parameter int CAPACITY = fprq_pkg::DEF_CAPACITY
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [CAPACITY-1:0]         leaf_vld,
  input  fprq_pkg::entry_t            leaf_data [CAPACITY],
  output logic                        best_vld,
  output logic [$clog2(CAPACITY)-1:0] best_idx,
  output fprq_pkg::entry_t            best_data
);
  import fprq_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int NPAD  = 2 ** IDX_W;

  logic             nd_vld  [1:2*NPAD-1];
  logic [IDX_W-1:0] nd_idx  [1:2*NPAD-1];
  entry_t           nd_data [1:2*NPAD-1];

  for (genvar i = 0; i < NPAD; i++) begin : g_leaf
    if (i < CAPACITY) begin : g_real
      assign nd_vld[NPAD+i]  = leaf_vld[i];
      assign nd_data[NPAD+i] = leaf_data[i];
    end else begin : g_pad
      assign nd_vld[NPAD+i]  = 1'b0;
      assign nd_data[NPAD+i] = '0;
    end
    assign nd_idx[NPAD+i] = IDX_W'(i);
  end

  for (genvar k = 1; k < NPAD; k++) begin : g_node
    logic take_left;
    assign take_left = nd_vld[2*k] &&
                       (!nd_vld[2*k+1] || nd_data[2*k].prio >= nd_data[2*k+1].prio);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        nd_vld[k] <= 1'b0;
      end else begin
        nd_vld[k] <= nd_vld[2*k] || nd_vld[2*k+1];
      end
      nd_idx[k]  <= take_left ? nd_idx[2*k]  : nd_idx[2*k+1];
      nd_data[k] <= take_left ? nd_data[2*k] : nd_data[2*k+1];
    end
  end

  assign best_vld  = nd_vld[1];
  assign best_idx  = nd_idx[1];
  assign best_data = nd_data[1];
endmodule

@@ rtl/fifo_priority_ready_queue.sv @@
`timescale 1ns / 1ps
`include "fifo_priority_ready_queue_macros.svh"
// Priority ready queue: a chain of entry cells in arrival order and a max tree.
// Depends on fprq_pkg, fprq_if, fprq_cell and fprq_tree.
//
// Usage:
//   in_if carries one request transaction: action (enqueue, dequeue, pick or
//   no operation), proc_handle and proc_priority. out_if returns exactly one
//   result transaction per request, in request order.
//   Enqueue, dequeue and no operation go straight to the execute step.
//   A pick first waits in a search step, as the registered max tree over the
//   cells has one register level per halving, and the pick waits for it to
//   settle over the current contents. One request is in flight at a time.
//   The result sits in an output register; a new request is taken while it
//   waits, and the block stalls in its execute step only while the previous
//   result has not been taken.
//   Reset empties the queue at once; the cell contents are left as they are.
//   A removal shifts all younger cells one place toward the head together,
//   so the arrival order is kept.
module fifo_priority_ready_queue #(
  parameter int CAPACITY = fprq_pkg::DEF_CAPACITY
) (
  input logic          clk,
  input logic          rst_n,
  fprq_in_if.sink      in_if,
  fprq_out_if.source   out_if
);
  import fprq_pkg::*;

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int LEVELS = IDX_W;
  localparam int WAIT_W = $clog2(LEVELS + 1);

  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_EXEC} state_t;

  state_t              state_r;
  action_t             op_r;
  entry_t              req_r;
  logic [WAIT_W-1:0]   wait_r;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic                out_valid_r;
  entry_t              out_data_r;
  logic                found_r;
  logic                empty_r;
  logic                over_r;

  entry_t              cell_q [CAPACITY];
  logic [CAPACITY-1:0] cell_vld;
  logic                best_vld;
  logic [IDX_W-1:0]    best_idx;
  entry_t              best_data;

  logic                out_free;
  logic                exec_go;
  logic                do_enq;
  logic                do_rm;
  logic                over_now;
  logic [IDX_W-1:0]    rm_pos;
  entry_t              rm_data;

  assign in_if.ready = (state_r == S_IDLE);
  assign out_free    = !out_valid_r || out_if.ready;
  assign exec_go     = (state_r == S_EXEC) && out_free;

  always_comb begin
    do_enq    = (op_r == ACT_ENQUEUE) && (count_r != CNT_W'(CAPACITY));
    over_now  = (op_r == ACT_ENQUEUE) && (count_r == CNT_W'(CAPACITY));
    do_rm     = ((op_r == ACT_DEQUEUE) || (op_r == ACT_PICK)) && (count_r != '0);
    rm_pos    = (op_r == ACT_PICK) ? best_idx : '0;
    rm_data   = (op_r == ACT_PICK) ? best_data : cell_q[0];
    count_nxt = count_r;
    if (do_enq) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_rm) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctl_t ctl;
    entry_t    shift_in;

    assign ctl.load  = exec_go && do_enq && (count_r == CNT_W'(i));
    assign ctl.shift = exec_go && do_rm && (IDX_W'(i) >= rm_pos);
    assign cell_vld[i] = (CNT_W'(i) < count_r);

    if (i == CAPACITY - 1) begin : g_last
      assign shift_in = '0;
    end else begin : g_mid
      assign shift_in = cell_q[i+1];
    end

    fprq_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .enq_data (req_r),
      .shift_in (shift_in),
      .q        (cell_q[i])
    );
  end

  fprq_tree #(
    .CAPACITY (CAPACITY)
  ) u_tree (
    .clk       (clk),
    .rst_n     (rst_n),
    .leaf_vld  (cell_vld),
    .leaf_data (cell_q),
    .best_vld  (best_vld),
    .best_idx  (best_idx),
    .best_data (best_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      wait_r      <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_if.valid) begin
            op_r  <= in_if.action;
            req_r <= '{handle: in_if.proc_handle, prio: in_if.proc_priority};
            if (in_if.action == ACT_PICK) begin
              wait_r  <= WAIT_W'(LEVELS);
              state_r <= S_SEARCH;
            end else begin
              state_r <= S_EXEC;
            end
          end
        end
        S_SEARCH: begin
          if (wait_r == WAIT_W'(1)) begin
            state_r <= S_EXEC;
          end
          wait_r <= wait_r - WAIT_W'(1);
        end
        S_EXEC: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      if (exec_go) begin
        out_valid_r <= 1'b1;
        count_r     <= count_nxt;
        out_data_r  <= do_rm ? rm_data : '0;
        found_r     <= do_rm;
        empty_r     <= (count_nxt == '0);
        over_r      <= over_now;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.out_handle   = out_data_r.handle;
  assign out_if.out_priority = out_data_r.prio;
  assign out_if.found        = found_r;
  assign out_if.queue_empty  = empty_r;
  assign out_if.overflow     = over_r;

  `FPRQ_ASSERT_SAME(a_count_max, 1'b1, count_r <= CNT_W'(CAPACITY))
  `FPRQ_ASSERT_NEXT(a_result_loaded, exec_go, out_valid_r && (empty_r == (count_r == '0)))
  `FPRQ_ASSERT_SAME(a_found_excl, out_valid_r, !(found_r && over_r))
  `FPRQ_ASSERT_SAME(a_pick_hit, (state_r == S_EXEC) && (op_r == ACT_PICK) && (count_r != '0),
                    best_vld && (CNT_W'(best_idx) < count_r))
endmodule

@@ tb/fifo_priority_ready_queue_tb.sv @@
`timescale 1ns / 1ps
// Testbench of the priority ready queue: directed and random request traffic,
// each result checked against a queue model. Depends on fprq_pkg, fprq_if and
// the fifo_priority_ready_queue RTL.
module fifo_priority_ready_queue_tb;
  import fprq_pkg::*;

  localparam int QUEUE_DEPTH    = DEF_CAPACITY;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [PRIO_W-1:0]   prio;
    logic                found;
    logic                queue_empty;
    logic                overflow;
  } outcome_t;

  logic clk;
  logic rst_n;

  fprq_in_if  req_ch ();
  fprq_out_if res_ch ();

  fifo_priority_ready_queue #(
    .CAPACITY (QUEUE_DEPTH)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (req_ch),
    .out_if (res_ch)
  );

  entry_t   queued_entries[$];
  outcome_t pending_outcomes[$];
  int       mismatch_count;
  int       tx_idle_pct;
  int       rx_idle_pct;
  int       rx_hold_cycles;
  int       stall_cycles;

  wire req_fire = req_ch.valid && req_ch.ready;
  wire res_fire = res_ch.valid && res_ch.ready;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic outcome_t apply_request(action_t act, logic [HANDLE_W-1:0] h,
                                             logic [PRIO_W-1:0] p);
    outcome_t r;
    entry_t   e;
    int       best;
    r = '0;
    case (act)
      ACT_ENQUEUE: begin
        if (queued_entries.size() >= QUEUE_DEPTH) begin
          r.overflow = 1'b1;
        end else begin
          e.handle = h;
          e.prio   = p;
          queued_entries.push_back(e);
        end
      end
      ACT_DEQUEUE: begin
        if (queued_entries.size() > 0) begin
          e = queued_entries.pop_front();
          r.handle = e.handle;
          r.prio   = e.prio;
          r.found  = 1'b1;
        end
      end
      ACT_PICK: begin
        if (queued_entries.size() > 0) begin
          best = 0;
          for (int i = 1; i < queued_entries.size(); i++) begin
            if (queued_entries[i].prio > queued_entries[best].prio) best = i;
          end
          r.handle = queued_entries[best].handle;
          r.prio   = queued_entries[best].prio;
          r.found  = 1'b1;
          queued_entries.delete(best);
        end
      end
      default: begin
      end
    endcase
    r.queue_empty = (queued_entries.size() == 0);
    return r;
  endfunction

  task automatic send_request(action_t act, logic [HANDLE_W-1:0] h, logic [PRIO_W-1:0] p);
    int gap;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.action        <= act;
    req_ch.proc_handle   <= h;
    req_ch.proc_priority <= p;
    do @(posedge clk); while (!req_ch.ready);
    pending_outcomes.push_back(apply_request(act, h, p));
  endtask

  task automatic wait_for_results();
    req_ch.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_requests();
    send_request(ACT_DEQUEUE, 16'hFFFF, 8'hFF);
    send_request(ACT_PICK, 16'hFFFF, 8'hFF);
    send_request(ACT_NOP, 16'hFFFF, 8'hFF);
  endtask

  task automatic test_fill_and_overflow();
    logic [HANDLE_W-1:0] h;
    logic [PRIO_W-1:0]   p;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      h = (i == 0) ? '0 : (i == QUEUE_DEPTH - 1) ? '1 : HANDLE_W'($urandom);
      p = (i == 0) ? '0 : (i == 3 || i == 9) ? '1 : PRIO_W'($urandom_range(254));
      send_request(ACT_ENQUEUE, h, p);
    end
    send_request(ACT_ENQUEUE, 16'hFFFF, 8'hFF);
    send_request(ACT_NOP, 16'h0000, 8'h00);
  endtask

  task automatic test_priority_ties();
    send_request(ACT_PICK, 16'h0000, 8'h00);
    send_request(ACT_PICK, 16'h0000, 8'h00);
    send_request(ACT_DEQUEUE, 16'h0000, 8'h00);
  endtask

  task automatic test_random_traffic(int count, int tx_pct, int rx_pct);
    int      enq_bias;
    int      roll;
    action_t act;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    enq_bias    = 50;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(2))
          0:       enq_bias = 25;
          1:       enq_bias = 50;
          default: enq_bias = 80;
        endcase
      end
      roll = $urandom_range(99);
      if ($urandom_range(99) < enq_bias) act = ACT_ENQUEUE;
      else if (roll < 10)                act = ACT_NOP;
      else if (roll < 50)                act = ACT_DEQUEUE;
      else                               act = ACT_PICK;
      send_request(act, HANDLE_W'($urandom),
                   $urandom_range(1) ? PRIO_W'($urandom_range(3)) : PRIO_W'($urandom));
    end
    wait_for_results();
  endtask

  task automatic test_backpressure();
    tx_idle_pct    = 0;
    rx_idle_pct    = 0;
    rx_hold_cycles = 80;
    for (int n = 0; n < 30; n++) begin
      send_request((n % 3 == 2) ? ACT_PICK : ACT_ENQUEUE, HANDLE_W'($urandom),
                   PRIO_W'($urandom));
    end
    wait_for_results();
  endtask

  initial begin : result_sink
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0) begin
        res_ch.ready <= 1'b0;
        rx_hold_cycles--;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin : result_check
    outcome_t want;
    outcome_t got;
    forever begin
      @(posedge clk);
      if (rst_n && res_fire) begin
        got = {res_ch.out_handle, res_ch.out_priority, res_ch.found,
               res_ch.queue_empty, res_ch.overflow};
        if (pending_outcomes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result transaction: handle=%h prio=%h found=%b empty=%b over=%b",
                     got.handle, got.prio, got.found, got.queue_empty, got.overflow);
        end else begin
          want = pending_outcomes.pop_front();
          if (got.handle !== want.handle || got.prio !== want.prio ||
              got.found !== want.found || got.queue_empty !== want.queue_empty ||
              got.overflow !== want.overflow) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("mismatch: expected handle=%h prio=%h found=%b empty=%b over=%b, got handle=%h prio=%h found=%b empty=%b over=%b",
                       want.handle, want.prio, want.found, want.queue_empty, want.overflow,
                       got.handle, got.prio, got.found, got.queue_empty, got.overflow);
          end
        end
      end
    end
  end

  initial begin : watchdog
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || req_fire || res_fire) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("fifo_priority_ready_queue_tb: FAIL");
    $finish;
  end

  initial begin : test_sequence
    mismatch_count       = 0;
    tx_idle_pct          = 0;
    rx_idle_pct          = 0;
    rx_hold_cycles       = 0;
    rst_n                <= 1'b0;
    req_ch.valid         <= 1'b0;
    req_ch.action        <= ACT_NOP;
    req_ch.proc_handle   <= '0;
    req_ch.proc_priority <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_requests();
    test_fill_and_overflow();
    test_priority_ties();
    wait_for_results();
    test_random_traffic(350, 19, 50);
    test_random_traffic(350, 50, 19);
    test_random_traffic(350, 0, 0);
    test_backpressure();

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_outcomes.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("fifo_priority_ready_queue_tb: PASS");
    end else begin
      $display("fifo_priority_ready_queue_tb: FAIL");
    end
    $finish;
  end
endmodule
